// ===== rtl/expanding_window_moving_average_core_macros.svh =====
// assertion helpers for the moving average core
`ifndef EXPANDING_WINDOW_MOVING_AVERAGE_CORE_MACROS_SVH
`define EXPANDING_WINDOW_MOVING_AVERAGE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define EWMA_ASSERT_IMP(name, clock, resetn, ante, cons) \
  name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define EWMA_ASSERT_NXT(name, clock, resetn, ante, cons) \
  name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define EWMA_ASSERT_IMP(name, clock, resetn, ante, cons)
`define EWMA_ASSERT_NXT(name, clock, resetn, ante, cons)
`endif

`endif

// ===== rtl/ewma_pkg.sv =====
package ewma_pkg;

  localparam int SAMPLE_W = 32;
  localparam int TOTAL_W  = SAMPLE_W + 6;
  localparam int LEN_W    = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [LEN_W-1:0] WINDOW_RESET = 7'd5;

  // register index decoded from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       series_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_result;
    logic signed [SAMPLE_W-1:0] y_average;
    logic                       result_last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/expanding_window_moving_average_core.sv =====
// Expanding-window moving average over Q16.16 samples. Each request carries x, y and a
// series-end mark; the result passes x through and gives the mean of the last N y values,
// where N is the samples seen in the series capped at window_length (APB register at
// byte 0, clamped to 1..MAX_WINDOW, reset 5). The mean truncates toward zero and
// saturates to 32 bits. After acceptance a request goes through a window read, a subtract
// and an add on the 38-bit running total, then a one bit per cycle restoring divider.
// The core takes one request at a time; a finished result sits in the output register
// while the next request is accepted.
`include "expanding_window_moving_average_core_macros.svh"

module expanding_window_moving_average_core #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ewma_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ewma_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ewma_pkg::ADDR_W-1:0]   paddr,
  input  logic [ewma_pkg::DATA_W-1:0]   pwdata,
  output logic [ewma_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int TW     = ewma_pkg::TOTAL_W;
  localparam int SW     = ewma_pkg::SAMPLE_W;
  localparam int LW     = ewma_pkg::LEN_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_SUB  = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_GO   = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  ewma_pkg::in_item_t      req_r;
  logic [LW-1:0]           cfg_len_r;
  logic [LW-1:0]           len_r;
  logic [LW-1:0]           len_eff;
  logic [LW-1:0]           seen_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [SLOT_W-1:0]       old_slot_r;
  logic [SLOT_W-1:0]       old_slot;
  logic [TW-1:0]           total_r;
  logic                    drop_r;
  logic                    neg_r;
  logic [SW-1:0]           rd_data_r;
  logic [SW-1:0]           mem [MAX_WINDOW];
  logic [31:0]             old_int;
  logic [31:0]             slot_inc;
  logic [LW:0]             seen_inc;
  logic                    in_acc;
  logic                    cfg_wr;
  logic                    out_load;
  logic                    series_done;
  logic                    out_valid_r;
  ewma_pkg::out_item_t     out_r;
  logic                    div_start;
  logic [TW-1:0]           div_quo;
  ewma_pkg::div_stat_t     div_stat;
  logic signed [SW-1:0]    avg;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ewma_pkg::REG_WINDOW_LENGTH);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == ewma_pkg::REG_WINDOW_LENGTH) ?
                    {{(ewma_pkg::DATA_W-LW){1'b0}}, cfg_len_r} : '0;

  // clamp length and locate the slot that leaves the window
  always_comb begin
    len_eff = cfg_len_r;
    if (len_eff == '0) begin
      len_eff = LW'(1);
    end
    if (32'(len_eff) > MAX_WINDOW) begin
      len_eff = LW'(MAX_WINDOW);
    end
    if (32'(slot_r) >= 32'(len_eff)) begin
      old_int = 32'(slot_r) - 32'(len_eff);
    end else begin
      old_int = 32'(slot_r) + 32'(MAX_WINDOW) - 32'(len_eff);
    end
    old_slot = old_int[SLOT_W-1:0];
    slot_inc = 32'(slot_r) + 32'd1;
    seen_inc = {1'b0, seen_r} + 1'b1;
  end

  assign out_load    = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign series_done = out_load && req_r.series_end;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: state_nxt = S_SUB;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_GO;
      S_GO:   state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_len_r   <= ewma_pkg::WINDOW_RESET;
      total_r     <= '0;
      seen_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        cfg_len_r <= pwdata[LW-1:0];
      end
      if (state_r == S_SUB && drop_r) begin
        total_r <= total_r - {{(TW-SW){rd_data_r[SW-1]}}, rd_data_r};
      end
      if (state_r == S_ADD) begin
        total_r <= total_r + {{(TW-SW){req_r.y_sample[SW-1]}}, req_r.y_sample};
        slot_r  <= (slot_inc >= 32'(MAX_WINDOW)) ? '0 : slot_inc[SLOT_W-1:0];
        seen_r  <= (seen_inc < {1'b0, len_r}) ? seen_inc[LW-1:0] : len_r;
      end
      if (series_done) begin
        total_r <= '0;
        seen_r  <= '0;
        slot_r  <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r      <= in_data;
      len_r      <= len_eff;
      old_slot_r <= old_slot;
      drop_r     <= (seen_r >= len_eff);
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem[old_slot_r];
    end
    if (state_r == S_ADD) begin
      mem[slot_r] <= req_r.y_sample;
    end
    if (state_r == S_GO) begin
      neg_r <= total_r[TW-1];
    end
    if (out_load) begin
      out_r.x_result    <= req_r.x_sample;
      out_r.y_average   <= avg;
      out_r.result_last <= req_r.series_end;
    end
  end

  assign div_start = (state_r == S_GO);

  ewma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r[TW-1] ? (~total_r + 1'b1) : total_r),
    .divisor  (seen_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // sign and saturate the quotient magnitude
  always_comb begin
    if (!neg_r) begin
      if (div_quo > TW'({1'b0, {(SW-1){1'b1}}})) begin
        avg = {1'b0, {(SW-1){1'b1}}};
      end else begin
        avg = div_quo[SW-1:0];
      end
    end else begin
      if (div_quo > TW'({1'b1, {(SW-1){1'b0}}})) begin
        avg = {1'b1, {(SW-1){1'b0}}};
      end else begin
        avg = ~div_quo[SW-1:0] + 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `EWMA_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_r == S_GO, seen_r != '0)
  `EWMA_ASSERT_IMP(a_div_running, clk, rst_n, state_r == S_DIV, div_stat.busy || div_stat.done)
  `EWMA_ASSERT_NXT(a_series_clear, clk, rst_n, series_done, !(|{seen_r, slot_r, total_r}))

endmodule

// ===== rtl/ewma_div.sv =====
module ewma_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ewma_pkg::TOTAL_W-1:0]   dividend,
  input  logic [ewma_pkg::LEN_W-1:0]     divisor,
  output logic [ewma_pkg::TOTAL_W-1:0]   quotient,
  output ewma_pkg::div_stat_t            stat
);

  localparam int CNT_W = $clog2(ewma_pkg::TOTAL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ewma_pkg::TOTAL_W - 1);

  logic [ewma_pkg::TOTAL_W-1:0] quo_r, quo_nxt;
  logic [ewma_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [ewma_pkg::LEN_W-1:0]   dvs_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r, done_r;
  logic [ewma_pkg::LEN_W:0]     trial;
  logic [ewma_pkg::LEN_W:0]     diff;
  logic                         fits;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_r, quo_r[ewma_pkg::TOTAL_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[ewma_pkg::LEN_W-1:0] : trial[ewma_pkg::LEN_W-1:0];
    quo_nxt = {quo_r[ewma_pkg::TOTAL_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LAST_STEP)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
